[rtl/min_priority_queue_core_defines.svh]
// Assertion macros used by the min priority queue core.
// Included by files that check their own logic; depends on clk and rst in scope.
`ifndef MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define MPQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mpq_pkg.sv]
// Package for the min priority queue: widths, codes and the item structs.
// Used by mpq_cell and min_priority_queue_core; depends on nothing.
package mpq_pkg;

  localparam int VALUE_W      = 32;
  localparam int OCC_W        = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic                      ins;
    logic                      ext;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                      vld;
    logic                      gt;
    logic signed [VALUE_W-1:0] val;
  } cell_t;

endpackage

[rtl/min_priority_queue_core.sv]
// Channel | dir | payload | accepted when
// req     | in  | req_t   | req_valid && req_ready
// rsp     | out | rsp_t   | rsp_valid && rsp_ready
// For each item all cells compare against the broadcast value at once and
// shift one place, so a new item is taken every cycle while the response register drains.
// The response is registered at acceptance, valid in the next cycle, and holds until taken.
// Reset clears the count and every cell's valid bit.
// A stalled response stalls the request side only when the response register is full.
// Top level of the min priority queue; depends on mpq_pkg, mpq_cell and the defines header.
// Values are kept sorted in a row of cells with the smallest in cell zero.
`include "min_priority_queue_core_defines.svh"

module min_priority_queue_core #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mpq_pkg::rsp_t rsp
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  rsp_t             rsp_next;
  cmd_t             cmd;
  cell_t            cells_out [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);

  assign cmd.ins   = accept && (req.action == ACT_INSERT) && !full;
  assign cmd.ext   = accept && (req.action == ACT_EXTRACT) && !empty;
  assign cmd.value = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left;
    cell_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cells_out[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cells_out[i+1];
    end
    mpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .state (cells_out[i])
    );
  end

  always_comb begin
    count_next            = count;
    rsp_next.result_value = '0;
    if (req.action == ACT_INSERT) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status = ST_INSERTED;
        count_next      = count + 1'b1;
      end
    end else begin
      if (empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        rsp_next.status       = ST_EXTRACTED;
        rsp_next.result_value = cells_out[0].val;
        count_next            = count - 1'b1;
      end
    end
    rsp_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `MPQ_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "count exceeds capacity")
  `MPQ_ASSERT(a_head_valid, cells_out[0].vld == !empty, "head cell valid disagrees with count")
  `MPQ_ASSERT_NXT(a_insert_count, cmd.ins, count == $past(count) + 1'b1, "insert did not count up")
  `MPQ_ASSERT_NXT(a_extract_rsp, cmd.ext, rsp_valid && rsp.status == ST_EXTRACTED, "extract lost")

endmodule

[rtl/mpq_cell.sv]
// One cell of the sorted queue row: holds a value and its valid bit.
// Depends on mpq_pkg; trades values with its left and right neighbors.
module mpq_cell (
  input  logic          clk,
  input  logic          rst,
  input  mpq_pkg::cmd_t cmd,
  input  mpq_pkg::cell_t left,
  input  mpq_pkg::cell_t right,
  output mpq_pkg::cell_t state
);
  import mpq_pkg::*;

  logic                      vld;
  logic                      vld_next;
  logic signed [VALUE_W-1:0] val;
  logic signed [VALUE_W-1:0] val_next;
  logic                      gt;

  // An empty cell counts as holding plus infinity.
  assign gt = !vld || (cmd.value < val);

  always_comb begin
    vld_next = vld;
    val_next = val;
    if (cmd.ins) begin
      if (gt) begin
        if (left.gt) begin
          vld_next = left.vld;
          val_next = left.val;
        end else begin
          vld_next = 1'b1;
          val_next = cmd.value;
        end
      end
    end else if (cmd.ext) begin
      vld_next = right.vld;
      val_next = right.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign state = '{vld: vld, gt: gt, val: val};

endmodule
